>>> src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the longest-prefix route counter: item
// layouts, action codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int MAX_ROUTES_DEF = 64;
    localparam int MAX_LINKS_DEF  = 16;

    localparam logic [5:0]  FULL_PREFIX = 6'd32;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_ROUTE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  entry_index;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [3:0]  link;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  out_link;
        logic [31:0] link_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic [5:0]  length;
        logic [3:0]  link;
    } route_t;

    typedef struct packed {
        logic load;        // capture item, clear scan state
        logic write_route; // store captured entry
        logic scan;        // step the table scan
        logic cnt_read;    // issue counter read
        logic cnt_update;  // update counter on a route item and present result
    } lpr_cmd_t;

    typedef struct packed {
        logic scan_done;
    } lpr_stat_t;

endpackage

>>> src/longest_prefix_route_counter.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_counter
// Route item: the scan reads min(route_count, MAX_ROUTES) table entries, one
// entry per cycle, then the chosen link's counter is read, updated and shown.
// Read item: counter value shown. Write item: entry stored, no result shown.
// Next item can be accepted in the cycle its predecessor's result is shown.
// Reset clears the counters and route_count; table entries are unset.
// ----------------------------------------------------------------------------
module longest_prefix_route_counter
    import lpr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int MAX_LINKS  = MAX_LINKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   req,
    output logic       done,
    output out_item_t  rsp,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata
);

    lpr_cmd_t  cmd;
    lpr_stat_t stat;

    lpr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (req.action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    lpr_datapath #(
        .MAX_ROUTES (MAX_ROUTES),
        .MAX_LINKS  (MAX_LINKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .done      (done)
    );

    // a result always closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.action == ACT_WRITE) |=> busy ##1 !busy)
        else $error("write item not completed in one cycle");

    a_no_result_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.action == ACT_WRITE) |=> ##1 !done)
        else $error("write item produced a result");

endmodule

>>> src/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl
// Sequencer for the route counter: decodes an accepted item and steps the
// datapath through write, scan, counter read and counter update.
// ----------------------------------------------------------------------------
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  lpr_stat_t  stat,
    output lpr_cmd_t   cmd,
    output logic       busy
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRITE  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CNT_RD = 6'b001000,
        S_CNT_WR = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_WRITE: state_next = S_WRITE;
                        ACT_ROUTE: state_next = S_SCAN;
                        ACT_READ:  state_next = S_CNT_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.write_route = 1'b1;
                state_next      = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                cmd.cnt_read = 1'b1;
                state_next   = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                cmd.cnt_update = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/lpr_datapath.sv
// ----------------------------------------------------------------------------
// lpr_datapath
// Route table memory with a one-entry-per-cycle prefix compare, per-link
// counter memory and the result register.
// ----------------------------------------------------------------------------
module lpr_datapath
    import lpr_pkg::*;
#(
    parameter int MAX_ROUTES = MAX_ROUTES_DEF,
    parameter int MAX_LINKS  = MAX_LINKS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  req,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata,
    input  lpr_cmd_t  cmd,
    output lpr_stat_t stat,
    output out_item_t rsp,
    output logic      done
);

    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam logic [12:0] ROUTES_EXT = 13'(MAX_ROUTES);
    localparam logic [8:0]  LINKS_EXT  = 9'(MAX_LINKS);

    route_t      route_mem [MAX_ROUTES];
    logic [31:0] cnt_mem [MAX_LINKS];

    in_item_t    item_reg;
    logic [6:0]  route_count_reg;
    logic [CW-1:0] scan_idx_reg;
    logic        rd_valid_reg;
    route_t      rd_data_reg;
    logic [5:0]  best_len_reg;
    logic [3:0]  chosen_reg;
    logic [MAX_LINKS-1:0] cnt_vld_reg;
    logic        cnt_rvld_reg;
    logic [31:0] cnt_rdata_reg;
    out_item_t   rsp_reg;
    logic        done_reg;

    logic [12:0]   idx_ext;
    logic [12:0]   rc_ext;
    logic [CW-1:0] limit;
    logic          issue;
    logic [31:0]   mask;
    logic          hit;
    logic [3:0]    tgt_link;
    logic [8:0]    tgt_ext;
    logic [LW-1:0] cnt_addr;
    logic          in_range;
    logic [31:0]   cnt_cur;
    logic [31:0]   cnt_new;
    logic          cnt_we;

    // ---- route table scan
    assign idx_ext = 13'(item_reg.entry_index);
    assign rc_ext  = 13'(route_count_reg);
    assign limit   = (rc_ext > ROUTES_EXT) ? CW'(ROUTES_EXT) : CW'(rc_ext);
    assign issue   = cmd.scan && (scan_idx_reg < limit);

    assign stat.scan_done = !issue && !rd_valid_reg;

    // length 0 gives an empty mask
    assign mask = (rd_data_reg.length == 6'd0) ? 32'd0
                : (32'hFFFF_FFFF << (FULL_PREFIX - rd_data_reg.length));
    assign hit  = ((item_reg.address & mask) == (rd_data_reg.address & mask))
                && (rd_data_reg.length > best_len_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.write_route && (idx_ext < ROUTES_EXT))
        begin
            route_mem[idx_ext[AW-1:0]] <= '{
                address: item_reg.address,
                length:  (item_reg.prefix_len > FULL_PREFIX) ? FULL_PREFIX
                                                             : item_reg.prefix_len,
                link:    item_reg.link
            };
        end
        if (issue)
        begin
            rd_data_reg <= route_mem[scan_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count_reg <= '0;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            best_len_reg    <= '0;
            chosen_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                route_count_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
                best_len_reg <= '0;
                chosen_reg   <= '0;
            end
            else
            begin
                rd_valid_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (rd_valid_reg && hit)
                begin
                    best_len_reg <= rd_data_reg.length;
                    chosen_reg   <= rd_data_reg.link;
                end
            end
        end
    end

    // ---- link counters: read, then update in the next cycle
    assign tgt_link = (item_reg.action == ACT_ROUTE) ? chosen_reg : item_reg.link;
    assign tgt_ext  = 9'(tgt_link);
    assign cnt_addr = tgt_ext[LW-1:0];
    assign in_range = (tgt_ext < LINKS_EXT);
    assign cnt_cur  = cnt_rvld_reg ? cnt_rdata_reg : 32'd0;
    assign cnt_new  = (item_reg.action != ACT_ROUTE) ? cnt_cur
                    : (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 32'd1;
    assign cnt_we   = cmd.cnt_update && in_range && (item_reg.action == ACT_ROUTE);

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_new;
        end
        if (cmd.cnt_read)
        begin
            cnt_rdata_reg <= cnt_mem[cnt_addr];
        end
    end

    // never-written counters read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg  <= '0;
            cnt_rvld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cnt_we)
            begin
                cnt_vld_reg[cnt_addr] <= 1'b1;
            end
            if (cmd.cnt_read)
            begin
                cnt_rvld_reg <= in_range && cnt_vld_reg[cnt_addr];
            end
            done_reg <= cmd.cnt_update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cnt_update)
        begin
            rsp_reg.out_link   <= tgt_link;
            rsp_reg.link_count <= in_range ? cnt_new : 32'd0;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

>>> tb/longest_prefix_route_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_prefix_route_counter_tb
// Self-checking bench for the route counter. Items go in through the
// start/busy handshake, results are caught on the done strobe. A scoreboard
// keeps its own routing table and link counters, predicts each result and
// compares it with what comes out. The run sweeps route_count over several
// settings, extremes included, under three sender idling profiles.
// ----------------------------------------------------------------------------
module longest_prefix_route_counter_tb
    import lpr_pkg::*;
;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SEG_ITEMS   = 96;

    class route_scoreboard;
        logic [31:0] tbl_addr [MAX_ROUTES_DEF];
        logic [5:0]  tbl_len  [MAX_ROUTES_DEF];
        logic [3:0]  tbl_link [MAX_ROUTES_DEF];
        logic [31:0] counts   [MAX_LINKS_DEF];
        logic [6:0]  route_count;
        out_item_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < MAX_ROUTES_DEF; i++)
            begin
                tbl_addr[i] = '0;
                tbl_len[i]  = '0;
                tbl_link[i] = '0;
            end
            for (int i = 0; i < MAX_LINKS_DEF; i++)
                counts[i] = '0;
            route_count = '0;
            errors      = 0;
        endfunction

        function void set_route_count(logic [6:0] v);
            route_count = v;
        endfunction

        function int scan_limit();
            return (route_count > MAX_ROUTES_DEF) ? MAX_ROUTES_DEF : int'(route_count);
        endfunction

        function logic [31:0] prefix_mask(logic [5:0] len);
            if (len == 6'd0)
                return 32'h0;
            if (len > FULL_PREFIX)
                return 32'hFFFF_FFFF;
            return 32'hFFFF_FFFF << (FULL_PREFIX - len);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // Called once per accepted item, in acceptance order
        function void note_item(in_item_t it);
            int          lim;
            logic [5:0]  best;
            logic [3:0]  chosen;
            logic [31:0] m;
            out_item_t   res;
            case (it.action)
                ACT_WRITE:
                begin
                    tbl_addr[it.entry_index] = it.address;
                    tbl_len[it.entry_index]  = (it.prefix_len > FULL_PREFIX) ?
                                               FULL_PREFIX : it.prefix_len;
                    tbl_link[it.entry_index] = it.link;
                end
                ACT_ROUTE:
                begin
                    lim    = scan_limit();
                    best   = '0;
                    chosen = '0;
                    // strictly longer only, so ties keep the earliest entry
                    for (int i = 0; i < lim; i++)
                    begin
                        m = prefix_mask(tbl_len[i]);
                        if (((it.address ^ tbl_addr[i]) & m) == 32'h0 && tbl_len[i] > best)
                        begin
                            best   = tbl_len[i];
                            chosen = tbl_link[i];
                        end
                    end
                    res.out_link   = chosen;
                    res.link_count = '0;
                    if (chosen < MAX_LINKS_DEF)
                    begin
                        if (counts[chosen] != COUNT_MAX)
                            counts[chosen] = counts[chosen] + 32'd1;
                        res.link_count = counts[chosen];
                    end
                    pending.push_back(res);
                end
                ACT_READ:
                begin
                    res.out_link   = it.link;
                    res.link_count = (it.link < MAX_LINKS_DEF) ? counts[it.link] : '0;
                    pending.push_back(res);
                end
                default: ; // unused action: no effect
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got link %0d count %0d",
                         $time, got.out_link, got.link_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_link !== want.out_link)
            begin
                $display("%0t: out_link mismatch: expected %0d, got %0d",
                         $time, want.out_link, got.out_link);
                errors++;
            end
            if (got.link_count !== want.link_count)
            begin
                $display("%0t: link_count mismatch: expected %0d, got %0d",
                         $time, want.link_count, got.link_count);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    in_item_t   req       = '0;
    logic       done;
    out_item_t  rsp;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = '0;

    route_scoreboard sb;
    int sender_idle_pct = 37;
    int cycle_count = 0;

    longest_prefix_route_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    function automatic in_item_t make_item(logic [1:0] act, logic [5:0] idx,
                                           logic [31:0] addr, logic [5:0] len,
                                           logic [3:0] lk);
        in_item_t it;
        it.action      = act;
        it.entry_index = idx;
        it.address     = addr;
        it.prefix_len  = len;
        it.link        = lk;
        return it;
    endfunction

    // Route entries cluster in a few networks so prefixes nest and compete
    function automatic in_item_t shape_route(input in_item_t it);
        int k;
        logic [7:0] net;
        case ($urandom_range(0, 3))
            0:       net = 8'h0A;
            1:       net = 8'hC0;
            2:       net = 8'hAC;
            default: net = 8'($urandom);
        endcase
        it.address    = {net, 24'($urandom)};
        it.prefix_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                    : 6'($urandom_range(0, 32));
        it.link       = 4'($urandom);
        // copy of another slot's prefix: exercises ties
        if ($urandom_range(0, 6) == 0)
        begin
            k = $urandom_range(0, MAX_ROUTES_DEF - 1);
            it.address    = sb.tbl_addr[k];
            it.prefix_len = sb.tbl_len[k];
        end
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int          pick;
        int          lim;
        int          k;
        logic [31:0] m;
        it   = make_item(2'($urandom), 6'($urandom), $urandom, 6'($urandom), 4'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            it.action = ACT_ROUTE;
            lim = sb.scan_limit();
            // mostly aim at a live entry, sometimes just missing it
            if (lim > 0 && $urandom_range(0, 99) < 70)
            begin
                k = $urandom_range(0, lim - 1);
                m = sb.prefix_mask(sb.tbl_len[k]);
                it.address = (sb.tbl_addr[k] & m) | (it.address & ~m);
                if ($urandom_range(0, 3) == 0 && sb.tbl_len[k] != 6'd0)
                    it.address = it.address ^ (32'h1 << (FULL_PREFIX - sb.tbl_len[k]));
            end
        end
        else if (pick < 75)
        begin
            it.action = ACT_WRITE;
            it = shape_route(it);
        end
        else if (pick < 95)
            it.action = ACT_READ;
        else
            it.action = ACT_UNUSED;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Let the block go quiet: no result owed and a write or ignored item finished
    task automatic drain(input int settle);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_route_count(input logic [6:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_route_count(v);
    endtask

    logic [6:0] count_plan [9] = '{7'd64, 7'd127, 7'd20, 7'd0, 7'd64, 7'd100,
                                   7'd127, 7'd1, 7'd64};
    int idle_plan [3] = '{37, 87, 0};

    initial
    begin
        sb = new();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: a route item goes to link 0
        send_item(make_item(ACT_ROUTE, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 4'hF));
        send_item(make_item(ACT_READ, 6'h00, 32'h0, 6'h00, 4'h0));
        send_item(make_item(ACT_READ, 6'h00, 32'h0, 6'h00, 4'hF));
        send_item(make_item(ACT_UNUSED, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 4'hF));
        // zero-length default, nested prefixes, a tie, an over-long length
        send_item(make_item(ACT_WRITE, 6'd0, 32'h0000_0000, 6'd0,  4'd5));
        send_item(make_item(ACT_WRITE, 6'd1, 32'h0A00_0000, 6'd8,  4'd1));
        send_item(make_item(ACT_WRITE, 6'd2, 32'h0A01_0000, 6'd16, 4'd2));
        send_item(make_item(ACT_WRITE, 6'd3, 32'h0A01_FFFF, 6'd16, 4'd3));
        send_item(make_item(ACT_WRITE, 6'd4, 32'hC0A8_0101, 6'd63, 4'd15));
        send_item(make_item(ACT_WRITE, 6'd5, 32'hFFFF_FFFF, 6'd32, 4'd14));
        drain(10);
        write_route_count(7'd6);
        send_item(make_item(ACT_ROUTE, 6'd0, 32'h0A01_0203, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'h0A02_0000, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'h0B00_0000, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'hC0A8_0101, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'hC0A8_0100, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'hFFFF_FFFF, 6'd0, 4'd0));
        send_item(make_item(ACT_ROUTE, 6'd0, 32'h0000_0000, 6'd0, 4'd0));
        send_item(make_item(ACT_READ,  6'd0, 32'h0, 6'd0, 4'd15));
        send_item(make_item(ACT_READ,  6'd0, 32'h0, 6'd0, 4'd2));
        send_item(make_item(ACT_READ,  6'd0, 32'h0, 6'd0, 4'd0));

        // fill every slot so any route_count scans written entries only
        for (int i = 0; i < MAX_ROUTES_DEF; i++)
            send_item(shape_route(make_item(ACT_WRITE, 6'(i), 32'h0, 6'd0, 4'd0)));

        for (int seg = 0; seg < 9; seg++)
        begin
            sender_idle_pct = idle_plan[seg / 3];
            drain(10);
            write_route_count(count_plan[seg]);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_item(random_item());
        end

        drain(80);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/lpr_pkg.sv
src/lpr_ctrl.sv
src/lpr_datapath.sv
src/longest_prefix_route_counter.sv
tb/longest_prefix_route_counter_tb.sv
